### rtl/core/teq_pkg.sv
// Shared package for the timed event queue: widths, kind and status codes.
// Used by the core, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
  localparam int QueueDepthDefault = 32;
  localparam int HandlerW = 16;
  localparam int TagW = 32;
  localparam int DelayW = 32;
  localparam int TimeW = 64;
  localparam int StatusW = 3;
  localparam int CountW = 6;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_REM_H = 2'd1,
    KIND_REM_HT = 2'd2,
    KIND_RUN = 2'd3
  } kind_t;

  localparam logic [StatusW-1:0] ST_SCHEDULED = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL = 3'd1;
  localparam logic [StatusW-1:0] ST_REMOVED = 3'd2;
  localparam logic [StatusW-1:0] ST_FIRED = 3'd3;
  localparam logic [StatusW-1:0] ST_NONE_DUE = 3'd4;
endpackage
`default_nettype wire

### rtl/core/timed_event_queue.sv
// Top level of the timed event queue: handshake, list sequencer and slot store.
// Depends on teq_pkg only.
//
//  Channel | Ports                                  | Handshake
//  input   | in_kind/handler_id/handler_tag/...     | start high, busy low
//  result  | out_status/fired_handler/.../last_of_run | out_valid, one cycle
//
// An add or a removal walks the pending slots one at a time, paced by the
// single read port of the slot store; a run walks one fired event at a time.
// busy stays high until the last word.
// Reset is synchronous and builds the whole free chain in parallel (links are flops).
// The receiver cannot stall; each result word is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_queue #(
  parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [teq_pkg::HandlerW-1:0]  in_handler_id,
  input  wire logic [teq_pkg::TagW-1:0]      in_handler_tag,
  input  wire logic [teq_pkg::DelayW-1:0]    in_delay_ticks,
  input  wire logic [teq_pkg::TimeW-1:0]     in_current_time,
  output logic                               out_valid,
  output logic [teq_pkg::StatusW-1:0]        out_status,
  output logic [teq_pkg::HandlerW-1:0]       out_fired_handler,
  output logic [teq_pkg::TagW-1:0]           out_fired_tag,
  output logic [teq_pkg::CountW-1:0]         out_removed_count,
  output logic                               out_last_of_run
);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);   // link width, 0 is null
  localparam int IW = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_REM_RD, S_REM_CMP, S_RUN_RD, S_RUN_CMP
  } state_t;

  state_t state_r;
  // Slot payload memory, one read port with registered data.
  logic [teq_pkg::TimeW-1:0]    mem_due [QUEUE_DEPTH];
  logic [teq_pkg::HandlerW-1:0] mem_h   [QUEUE_DEPTH];
  logic [teq_pkg::TagW-1:0]     mem_tag [QUEUE_DEPTH];
  logic [teq_pkg::TimeW-1:0]    rd_due_r;
  logic [teq_pkg::HandlerW-1:0] rd_h_r;
  logic [teq_pkg::TagW-1:0]     rd_tag_r;
  logic [LW-1:0] link_r [QUEUE_DEPTH];
  logic [LW-1:0] pend_head_r, free_head_r, prev_r, cur_r, new_r;
  logic [LW:0]   steps_r;
  logic [teq_pkg::CountW-1:0] cnt_r;
  logic [teq_pkg::HandlerW-1:0] h_r;
  logic [teq_pkg::TagW-1:0] tag_r;
  logic [teq_pkg::TimeW-1:0] key_r;
  logic use_tag_r, fired_r;

  logic          wr_en;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [LW-1:0] cur_next;

  assign busy = (state_r != S_IDLE);
  assign rd_idx = IW'(cur_r - LW'(1));
  assign cur_next = link_r[rd_idx];
  assign wr_en = (state_r == S_IDLE) && start && (in_kind == teq_pkg::KIND_ADD)
                 && (free_head_r != '0);
  assign wr_idx = IW'(free_head_r - LW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_due[wr_idx] <= in_current_time + teq_pkg::TimeW'(in_delay_ticks);
      mem_h[wr_idx]   <= in_handler_id;
      mem_tag[wr_idx] <= in_handler_tag;
    end
    rd_due_r <= mem_due[rd_idx];
    rd_h_r   <= mem_h[rd_idx];
    rd_tag_r <= mem_tag[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        link_r[i] <= (i == QUEUE_DEPTH - 1) ? '0 : LW'(i + 2);
      end
      pend_head_r <= '0;
      free_head_r <= LW'(1);
      out_valid <= 1'b0;
      out_status <= '0;
      out_fired_handler <= '0;
      out_fired_tag <= '0;
      out_removed_count <= '0;
      out_last_of_run <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            h_r <= in_handler_id;
            tag_r <= in_handler_tag;
            key_r <= (in_kind == teq_pkg::KIND_RUN) ? in_current_time
                     : in_current_time + teq_pkg::TimeW'(in_delay_ticks);
            use_tag_r <= (in_kind == teq_pkg::KIND_REM_HT);
            prev_r <= '0;
            cur_r <= pend_head_r;
            steps_r <= '0;
            cnt_r <= '0;
            fired_r <= 1'b0;
            case (in_kind)
              teq_pkg::KIND_ADD: begin
                if (free_head_r == '0) begin
                  out_valid <= 1'b1;
                  out_status <= teq_pkg::ST_FULL;
                  out_fired_handler <= '0;
                  out_fired_tag <= '0;
                  out_removed_count <= '0;
                  out_last_of_run <= 1'b1;
                end else begin
                  new_r <= free_head_r;
                  free_head_r <= link_r[wr_idx];
                  state_r <= S_ADD_RD;
                end
              end
              teq_pkg::KIND_RUN: begin
                state_r <= S_RUN_RD;
              end
              default: state_r <= S_REM_RD;
            endcase
          end
        end
        S_ADD_RD: begin
          if (cur_r == '0 || steps_r == (LW+1)'(QUEUE_DEPTH)) begin
            link_r[IW'(new_r - LW'(1))] <= cur_r;
            if (prev_r == '0) pend_head_r <= new_r;
            else link_r[IW'(prev_r - LW'(1))] <= new_r;
            out_valid <= 1'b1;
            out_status <= teq_pkg::ST_SCHEDULED;
            out_fired_handler <= '0;
            out_fired_tag <= '0;
            out_removed_count <= '0;
            out_last_of_run <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_ADD_CMP;
          end
        end
        S_ADD_CMP: begin
          if (rd_due_r > key_r) begin
            steps_r <= (LW+1)'(QUEUE_DEPTH);
          end else begin
            prev_r <= cur_r;
            cur_r <= cur_next;
            steps_r <= steps_r + 1'b1;
          end
          state_r <= S_ADD_RD;
        end
        S_REM_RD: begin
          if (cur_r == '0 || steps_r == (LW+1)'(QUEUE_DEPTH)) begin
            out_valid <= 1'b1;
            out_status <= teq_pkg::ST_REMOVED;
            out_fired_handler <= '0;
            out_fired_tag <= '0;
            out_removed_count <= cnt_r;
            out_last_of_run <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_REM_CMP;
          end
        end
        S_REM_CMP: begin
          if (rd_h_r == h_r && (!use_tag_r || rd_tag_r == tag_r)) begin
            if (prev_r == '0) pend_head_r <= cur_next;
            else link_r[IW'(prev_r - LW'(1))] <= cur_next;
            link_r[rd_idx] <= free_head_r;
            free_head_r <= cur_r;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            prev_r <= cur_r;
          end
          cur_r <= cur_next;
          steps_r <= steps_r + 1'b1;
          state_r <= S_REM_RD;
        end
        S_RUN_RD: begin
          // The word for each fired event goes out only once the next head is
          // known, so the final word can carry the last flag.
          if (cur_r == '0 || steps_r == (LW+1)'(QUEUE_DEPTH)) begin
            out_valid <= 1'b1;
            out_status <= fired_r ? teq_pkg::ST_FIRED : teq_pkg::ST_NONE_DUE;
            out_fired_handler <= fired_r ? h_r : '0;
            out_fired_tag <= fired_r ? tag_r : '0;
            out_removed_count <= '0;
            out_last_of_run <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_RUN_CMP;
          end
        end
        S_RUN_CMP: begin
          if (rd_due_r > key_r) begin
            out_valid <= 1'b1;
            out_status <= fired_r ? teq_pkg::ST_FIRED : teq_pkg::ST_NONE_DUE;
            out_fired_handler <= fired_r ? h_r : '0;
            out_fired_tag <= fired_r ? tag_r : '0;
            out_removed_count <= '0;
            out_last_of_run <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (fired_r) begin
              out_valid <= 1'b1;
              out_status <= teq_pkg::ST_FIRED;
              out_fired_handler <= h_r;
              out_fired_tag <= tag_r;
              out_removed_count <= '0;
              out_last_of_run <= 1'b0;
            end
            fired_r <= 1'b1;
            h_r <= rd_h_r;
            tag_r <= rd_tag_r;
            pend_head_r <= cur_next;
            link_r[rd_idx] <= free_head_r;
            free_head_r <= cur_r;
            cur_r <= cur_next;
            steps_r <= steps_r + 1'b1;
            state_r <= S_RUN_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/teq_checker.sv
// Port-level checker for the timed event queue, bound to the top level.
// Depends on teq_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module teq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [2:0] out_status,
  input wire logic [15:0] out_fired_handler,
  input wire logic [5:0] out_removed_count,
  input wire logic       out_last_of_run
);
  a_word_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy) else $error("busy after last word");
  a_not_last_implies_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_status == teq_pkg::ST_FIRED)
    else $error("non-final word that is not a fired event");
  a_no_word_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(busy) && !$past(start) |-> !out_valid) else $error("word without item");
  a_handler_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != teq_pkg::ST_FIRED |-> out_fired_handler == '0)
    else $error("handler set on non-fired word");
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != teq_pkg::ST_REMOVED |-> out_removed_count == '0)
    else $error("count set on non-removal word");
endmodule

bind timed_event_queue teq_checker u_teq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_fired_handler(out_fired_handler),
  .out_removed_count(out_removed_count), .out_last_of_run(out_last_of_run)
);
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for timed_event_queue: a queue of command words drives the
// block, an internal sorted-list predictor builds expected result words, a monitor checks.
// Depends on teq_pkg and the timed_event_queue RTL.
`timescale 1ns / 1ps
module testbench;
  localparam int Depth = teq_pkg::QueueDepthDefault;

  typedef struct packed {
    teq_pkg::kind_t kind;
    logic [teq_pkg::HandlerW-1:0] handler;
    logic [teq_pkg::TagW-1:0] tag;
    logic [teq_pkg::DelayW-1:0] delay;
    logic [teq_pkg::TimeW-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [teq_pkg::StatusW-1:0] status;
    logic [teq_pkg::HandlerW-1:0] handler;
    logic [teq_pkg::TagW-1:0] tag;
    logic [teq_pkg::CountW-1:0] count;
    logic last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [teq_pkg::HandlerW-1:0] in_handler_id = '0;
  logic [teq_pkg::TagW-1:0] in_handler_tag = '0;
  logic [teq_pkg::DelayW-1:0] in_delay_ticks = '0;
  logic [teq_pkg::TimeW-1:0] in_current_time = '0;
  logic out_valid;
  logic [teq_pkg::StatusW-1:0] out_status;
  logic [teq_pkg::HandlerW-1:0] out_fired_handler;
  logic [teq_pkg::TagW-1:0] out_fired_tag;
  logic [teq_pkg::CountW-1:0] out_removed_count;
  logic out_last_of_run;

  timed_event_queue u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_handler_id(in_handler_id), .in_handler_tag(in_handler_tag),
    .in_delay_ticks(in_delay_ticks), .in_current_time(in_current_time),
    .out_valid(out_valid), .out_status(out_status), .out_fired_handler(out_fired_handler),
    .out_fired_tag(out_fired_tag), .out_removed_count(out_removed_count),
    .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  cmd_t pending_cmds[$];
  word_t expected_words[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit quiet_stretch = 1'b0;
  bit word_taken = 1'b0;

  // Predictor state: pending events in due order, each with handler and tag.
  logic [teq_pkg::TimeW-1:0] ev_due[$];
  logic [teq_pkg::HandlerW-1:0] ev_handler[$];
  logic [teq_pkg::TagW-1:0] ev_tag[$];

  function automatic word_t mk_word(logic [teq_pkg::StatusW-1:0] st,
                                    logic [teq_pkg::HandlerW-1:0] h,
                                    logic [teq_pkg::TagW-1:0] t,
                                    logic [teq_pkg::CountW-1:0] c);
    word_t w;
    w.status = st; w.handler = h; w.tag = t; w.count = c; w.last = 1'b0;
    return w;
  endfunction

  function automatic void predict_schedule(cmd_t c);
    word_t w;
    int pos;
    int n;
    logic [teq_pkg::TimeW-1:0] due;
    n = 0;
    case (c.kind)
      teq_pkg::KIND_ADD: begin
        if (ev_due.size() >= Depth) begin
          expected_words.push_back(mk_word(teq_pkg::ST_FULL, '0, '0, '0));
        end else begin
          due = c.now + teq_pkg::TimeW'(c.delay);
          pos = 0;
          while (pos < ev_due.size() && ev_due[pos] <= due) pos++;
          ev_due.insert(pos, due);
          ev_handler.insert(pos, c.handler);
          ev_tag.insert(pos, c.tag);
          expected_words.push_back(mk_word(teq_pkg::ST_SCHEDULED, '0, '0, '0));
        end
      end
      teq_pkg::KIND_REM_H, teq_pkg::KIND_REM_HT: begin
        pos = 0;
        while (pos < ev_due.size()) begin
          if (ev_handler[pos] == c.handler &&
              (c.kind == teq_pkg::KIND_REM_H || ev_tag[pos] == c.tag)) begin
            ev_due.delete(pos); ev_handler.delete(pos); ev_tag.delete(pos);
            n++;
          end else begin
            pos++;
          end
        end
        expected_words.push_back(mk_word(teq_pkg::ST_REMOVED, '0, '0,
                                         teq_pkg::CountW'(n)));
      end
      default: begin
        while (ev_due.size() > 0 && ev_due[0] <= c.now) begin
          expected_words.push_back(mk_word(teq_pkg::ST_FIRED, ev_handler[0], ev_tag[0],
                                           '0));
          void'(ev_due.pop_front()); void'(ev_handler.pop_front());
          void'(ev_tag.pop_front());
          n++;
        end
        if (n == 0) expected_words.push_back(mk_word(teq_pkg::ST_NONE_DUE, '0, '0, '0));
      end
    endcase
    w = expected_words[$];
    w.last = 1'b1;
    expected_words[$] = w;
  endfunction

  // Driver: at the falling edge, present the next word or idle. A word that has
  // not yet been taken is held unchanged.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || word_taken) begin
        if (pending_cmds.size() > 0 && (quiet_stretch || $urandom_range(99) >= 19)) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_kind <= c.kind;
          in_handler_id <= c.handler;
          in_handler_tag <= c.tag;
          in_delay_ticks <= c.delay;
          in_current_time <= c.now;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Acceptance and result checking at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      word_taken = start && !busy;
      if (start && !busy) begin
        cmd_t c;
        c.kind = teq_pkg::kind_t'(in_kind); c.handler = in_handler_id;
        c.tag = in_handler_tag; c.delay = in_delay_ticks; c.now = in_current_time;
        predict_schedule(c);
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d", out_status);
          errors++;
        end else begin
          word_t e;
          e = expected_words.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status); errors++;
          end
          if (out_fired_handler !== e.handler) begin
            $error("fired_handler: expected %0h, got %0h", e.handler, out_fired_handler);
            errors++;
          end
          if (out_fired_tag !== e.tag) begin
            $error("fired_tag: expected %0h, got %0h", e.tag, out_fired_tag); errors++;
          end
          if (out_removed_count !== e.count) begin
            $error("removed_count: expected %0d, got %0d", e.count, out_removed_count);
            errors++;
          end
          if (out_last_of_run !== e.last) begin
            $error("last_of_run: expected %0b, got %0b", e.last, out_last_of_run); errors++;
          end
        end
      end
    end
  end

  function automatic cmd_t mk_cmd(teq_pkg::kind_t k, logic [teq_pkg::HandlerW-1:0] h,
                                  logic [teq_pkg::TagW-1:0] t,
                                  logic [teq_pkg::DelayW-1:0] d,
                                  logic [teq_pkg::TimeW-1:0] now);
    cmd_t c;
    c.kind = k; c.handler = h; c.tag = t; c.delay = d; c.now = now;
    return c;
  endfunction

  initial begin
    logic [teq_pkg::TimeW-1:0] clock_now;
    int pick;
    int live;
    logic [teq_pkg::HandlerW-1:0] h;
    // Directed part: extremes, equal due times, wrapped due time, full pool, no match.
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_RUN, '0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, '1));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_ADD, 16'h0001, 32'h1, 32'd10, 64'd0));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_ADD, 16'h0002, 32'h2, 32'd10, 64'd0));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_ADD, 16'h0003, 32'h3, 32'd5, 64'd5));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_RUN, '0, '0, '0, 64'd9));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_RUN, '0, '0, '0, 64'd10));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_REM_H, 16'h1234, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_RUN, '0, '0, '0, '1));
    for (int i = 0; i < Depth + 1; i++)
      pending_cmds.push_back(mk_cmd(teq_pkg::KIND_ADD, 16'(i % 3), 32'(i % 2), 32'(i),
                                    64'd100));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_REM_HT, 16'd1, 32'd1, '0, '0));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_REM_H, 16'd0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(teq_pkg::KIND_RUN, '0, '0, '0, '1));

    // Random part: a rising clock with small handler set so removals match.
    clock_now = {$urandom, $urandom};
    live = 0;
    for (int i = 0; i < 375; i++) begin
      pick = $urandom_range(99);
      h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      if (pick < 55 && live < Depth + 2) begin
        pending_cmds.push_back(mk_cmd(teq_pkg::KIND_ADD, h,
                                      ($urandom_range(3) == 0) ? $urandom
                                       : 32'($urandom_range(3)),
                                      ($urandom_range(7) == 0) ? $urandom
                                       : 32'($urandom_range(200)), clock_now));
        live++;
      end else if (pick < 70) begin
        pending_cmds.push_back(mk_cmd(teq_pkg::KIND_REM_H, h, $urandom, $urandom,
                                      {$urandom, $urandom}));
      end else if (pick < 82) begin
        pending_cmds.push_back(mk_cmd(teq_pkg::KIND_REM_HT, h, 32'($urandom_range(3)),
                                      $urandom, {$urandom, $urandom}));
      end else begin
        clock_now = clock_now + 64'($urandom_range(150));
        pending_cmds.push_back(mk_cmd(teq_pkg::KIND_RUN, h, $urandom, $urandom,
                                      clock_now));
        live = live / 2;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        quiet_stretch = 1'b1;
        repeat (3000) @(posedge clk);
        quiet_stretch = 1'b0;
      end
    join_none
    wait (pending_cmds.size() == 0);
    wait (!start);
    @(posedge clk);
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
